[hw/rtl/cpaf_pkg.sv]
// Package for the contiguous page allocator.
// Holds the field widths, request codes, fit mode codes and status codes used by the interfaces and the top level.
// Depends on nothing.
`default_nettype none

package cpaf_pkg;

	localparam int REQ_TYPE_W   = 1;
	localparam int PROGRAM_ID_W = 8;
	localparam int SIZE_KB_W    = 10;
	localparam int STATUS_W     = 3;
	localparam int PAGES_W      = 6;
	localparam int START_PAGE_W = 5;
	localparam int FREE_PAGES_W = 6;
	localparam int FREE_RUNS_W  = 5;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_KILL  = 1'b1;

	localparam logic FIT_BEST  = 1'b0;
	localparam logic FIT_WORST = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_NOSPACE = 3'd1,
		ST_PRESENT = 3'd2,
		ST_ABSENT  = 3'd3,
		ST_ZERO    = 3'd4
	} status_t;

endpackage

`default_nettype wire

[hw/rtl/cpaf_if.sv]
// Handshake interfaces of the contiguous page allocator: request, response and configuration.
// Depends on cpaf_pkg for the field widths.
`default_nettype none

interface cpaf_req_if;
	logic                               valid;
	logic                               ready;
	logic [cpaf_pkg::REQ_TYPE_W-1:0]    req_type;
	logic [cpaf_pkg::PROGRAM_ID_W-1:0]  program_id;
	logic [cpaf_pkg::SIZE_KB_W-1:0]     size_kb;

	modport source (output valid, req_type, program_id, size_kb, input ready);
	modport sink (input valid, req_type, program_id, size_kb, output ready);
endinterface

interface cpaf_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [cpaf_pkg::STATUS_W-1:0]      status;
	logic [cpaf_pkg::PAGES_W-1:0]       pages;
	logic [cpaf_pkg::START_PAGE_W-1:0]  start_page;
	logic [cpaf_pkg::FREE_PAGES_W-1:0]  free_pages;
	logic [cpaf_pkg::FREE_RUNS_W-1:0]   free_runs;

	modport source (output valid, status, pages, start_page, free_pages, free_runs, input ready);
	modport sink (input valid, status, pages, start_page, free_pages, free_runs, output ready);
endinterface

interface cpaf_cfg_if;
	logic valid;
	logic ready;
	logic fit_mode;

	modport source (output valid, fit_mode, input ready);
	modport sink (input valid, fit_mode, output ready);
endinterface

`default_nettype wire

[hw/rtl/cpaf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module cpaf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/contiguous_page_allocator_fit.sv]
// Top level of the contiguous page allocator with best-fit and worst-fit placement.
// Depends on cpaf_pkg, the interfaces in cpaf_if and the page owner RAM cpaf_ram.
//
// The block keeps the owner id of every page in a RAM and a used bit per page in flip-flops,
// which reset clears, so the map starts empty with no clearing pass. Each request is handled
// one at a time. An allocate or kill walks the map through the single RAM read port, one page
// per cycle, checking ownership and tracking free runs in the same walk; an allocate then writes
// its pages one per cycle. A kill or a refused allocate has no write pass, and a zero size or
// id zero is answered without a walk. A finished word waits in the output register while the
// next request is taken.
`default_nettype none

module contiguous_page_allocator_fit #(
	parameter int NUM_PAGES = 32,
	parameter int PAGE_KB   = 4,
	parameter int ID_WIDTH  = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	cpaf_req_if.sink   req,
	cpaf_rsp_if.source rsp,
	cpaf_cfg_if.sink   cfg
);

	localparam int PW   = $clog2(NUM_PAGES);
	localparam int CW   = $clog2(NUM_PAGES + 1);
	localparam int KBW  = $clog2(NUM_PAGES * PAGE_KB + 1);
	localparam int CMPW = (KBW > cpaf_pkg::SIZE_KB_W) ? KBW : cpaf_pkg::SIZE_KB_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_WRITE,
		S_DONE
	} state_t;

	state_t                         state_q;
	logic                           fit_mode_q;
	logic [NUM_PAGES-1:0]           used_q;
	logic [CW-1:0]                  free_q;
	logic [CW-1:0]                  runs_q;

	logic                           kill_q;
	logic [ID_WIDTH-1:0]            id_q;
	logic [cpaf_pkg::SIZE_KB_W-1:0] kb_q;

	logic [CW-1:0]                  scan_q;
	logic                           rd_vld_s1;
	logic                           rd_used_s1;
	logic [PW-1:0]                  rd_idx_s1;

	logic                           present_q;
	logic [CW-1:0]                  kcnt_q;
	logic [CW-1:0]                  runs_acc_q;
	logic                           prev_free_q;

	logic [CW-1:0]                  run_len_q;
	logic [KBW-1:0]                 run_kb_q;
	logic [PW-1:0]                  run_start_q;
	logic                           found_q;
	logic [CW-1:0]                  best_len_q;
	logic [PW-1:0]                  best_start_q;

	logic [PW-1:0]                  wr_ptr_q;
	logic [KBW-1:0]                 acc_q;
	logic [CW-1:0]                  wcnt_q;

	cpaf_pkg::status_t              res_status_q;
	logic [CW-1:0]                  res_pages_q;
	logic [PW-1:0]                  res_start_q;

	logic                           rsp_vld_q;
	cpaf_pkg::status_t              rsp_status_q;
	logic [CW-1:0]                  rsp_pages_q;
	logic [PW-1:0]                  rsp_start_q;
	logic [CW-1:0]                  rsp_free_q;
	logic [CW-1:0]                  rsp_runs_q;

	logic [ID_WIDTH-1:0]            ram_rdata;
	logic [PW-1:0]                  scan_idx;
	logic                           scan_live;
	logic                           cur_free;
	logic                           hit;
	logic                           free_after;
	logic                           run_fits;
	logic                           run_better;
	logic [KBW-1:0]                 acc_n;
	logic [CW-1:0]                  wcnt_n;
	logic [ID_WIDTH-1:0]            req_id;
	logic                           req_fire;
	logic                           rsp_load;

	assign scan_idx   = scan_q[PW-1:0];
	assign scan_live  = (scan_q != CW'(NUM_PAGES));
	assign cur_free   = scan_live ? !used_q[scan_idx] : 1'b0;
	assign hit        = rd_vld_s1 && rd_used_s1 && (ram_rdata == id_q);
	assign free_after = !rd_used_s1 || hit;
	assign run_fits   = (CMPW'(run_kb_q) >= CMPW'(kb_q));
	assign run_better = !found_q ||
		((fit_mode_q == cpaf_pkg::FIT_BEST) && (run_len_q < best_len_q)) ||
		((fit_mode_q == cpaf_pkg::FIT_WORST) && (run_len_q > best_len_q));
	assign acc_n      = acc_q + KBW'(PAGE_KB);
	assign wcnt_n     = wcnt_q + CW'(1);
	assign req_id     = ID_WIDTH'(req.program_id);

	assign req.ready  = (state_q == S_IDLE);
	assign req_fire   = req.valid && req.ready;
	assign cfg.ready  = 1'b1;
	assign rsp_load   = (state_q == S_DONE) && (!rsp_vld_q || rsp.ready);

	assign rsp.valid      = rsp_vld_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.pages      = cpaf_pkg::PAGES_W'(rsp_pages_q);
	assign rsp.start_page = cpaf_pkg::START_PAGE_W'(rsp_start_q);
	assign rsp.free_pages = cpaf_pkg::FREE_PAGES_W'(rsp_free_q);
	assign rsp.free_runs  = cpaf_pkg::FREE_RUNS_W'(rsp_runs_q);

	cpaf_ram #(
		.WIDTH(ID_WIDTH),
		.DEPTH(NUM_PAGES)
	) u_owner_ram (
		.clk  (clk),
		.we   (state_q == S_WRITE),
		.waddr(wr_ptr_q),
		.wdata(id_q),
		.raddr(scan_idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fit_mode_q   <= cpaf_pkg::FIT_BEST;
			used_q       <= '0;
			free_q       <= CW'(NUM_PAGES);
			runs_q       <= CW'(1);
			kill_q       <= 1'b0;
			id_q         <= '0;
			kb_q         <= '0;
			scan_q       <= '0;
			rd_vld_s1    <= 1'b0;
			rd_used_s1   <= 1'b0;
			rd_idx_s1    <= '0;
			present_q    <= 1'b0;
			kcnt_q       <= '0;
			runs_acc_q   <= '0;
			prev_free_q  <= 1'b0;
			run_len_q    <= '0;
			run_kb_q     <= '0;
			run_start_q  <= '0;
			found_q      <= 1'b0;
			best_len_q   <= '0;
			best_start_q <= '0;
			wr_ptr_q     <= '0;
			acc_q        <= '0;
			wcnt_q       <= '0;
			res_status_q <= cpaf_pkg::ST_OK;
			res_pages_q  <= '0;
			res_start_q  <= '0;
			rsp_vld_q    <= 1'b0;
			rsp_status_q <= cpaf_pkg::ST_OK;
			rsp_pages_q  <= '0;
			rsp_start_q  <= '0;
			rsp_free_q   <= '0;
			rsp_runs_q   <= '0;
		end else begin
			if (cfg.valid) begin
				fit_mode_q <= cfg.fit_mode;
			end

			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end

			rd_vld_s1  <= (state_q == S_SCAN) && scan_live;
			rd_used_s1 <= scan_live ? used_q[scan_idx] : 1'b1;
			rd_idx_s1  <= scan_idx;

			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						kill_q       <= (req.req_type == cpaf_pkg::REQ_KILL);
						id_q         <= req_id;
						kb_q         <= req.size_kb;
						scan_q       <= '0;
						present_q    <= 1'b0;
						kcnt_q       <= '0;
						runs_acc_q   <= '0;
						prev_free_q  <= 1'b0;
						run_len_q    <= '0;
						run_kb_q     <= '0;
						found_q      <= 1'b0;
						best_len_q   <= '0;
						best_start_q <= '0;
						res_pages_q  <= '0;
						res_start_q  <= '0;
						priority if (req.req_type == cpaf_pkg::REQ_KILL && req_id == '0) begin
							res_status_q <= cpaf_pkg::ST_ABSENT;
							state_q      <= S_DONE;
						end else if (req.req_type == cpaf_pkg::REQ_KILL) begin
							state_q <= S_SCAN;
						end else if (req.size_kb == '0) begin
							res_status_q <= cpaf_pkg::ST_ZERO;
							state_q      <= S_DONE;
						end else if (req_id == '0) begin
							res_status_q <= cpaf_pkg::ST_PRESENT;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end

				S_SCAN: begin
					scan_q <= scan_q + CW'(1);
					if (!scan_live) begin
						state_q <= S_DECIDE;
					end

					if (hit) begin
						present_q <= 1'b1;
					end
					if (rd_vld_s1 && kill_q) begin
						if (hit) begin
							used_q[rd_idx_s1] <= 1'b0;
							kcnt_q            <= kcnt_q + CW'(1);
						end
						if (free_after && !prev_free_q) begin
							runs_acc_q <= runs_acc_q + CW'(1);
						end
						prev_free_q <= free_after;
					end

					if (cur_free) begin
						if (run_len_q == '0) begin
							run_start_q <= scan_idx;
						end
						run_len_q <= run_len_q + CW'(1);
						run_kb_q  <= run_kb_q + KBW'(PAGE_KB);
					end else begin
						if (run_len_q != '0 && run_fits && run_better) begin
							found_q      <= 1'b1;
							best_len_q   <= run_len_q;
							best_start_q <= run_start_q;
						end
						run_len_q <= '0;
						run_kb_q  <= '0;
					end
				end

				S_DECIDE: begin
					if (kill_q) begin
						if (kcnt_q == '0) begin
							res_status_q <= cpaf_pkg::ST_ABSENT;
						end else begin
							res_status_q <= cpaf_pkg::ST_OK;
							res_pages_q  <= kcnt_q;
							free_q       <= free_q + kcnt_q;
							runs_q       <= runs_acc_q;
						end
						state_q <= S_DONE;
					end else if (present_q) begin
						res_status_q <= cpaf_pkg::ST_PRESENT;
						state_q      <= S_DONE;
					end else if (!found_q) begin
						res_status_q <= cpaf_pkg::ST_NOSPACE;
						state_q      <= S_DONE;
					end else begin
						wr_ptr_q <= best_start_q;
						acc_q    <= '0;
						wcnt_q   <= '0;
						state_q  <= S_WRITE;
					end
				end

				S_WRITE: begin
					used_q[wr_ptr_q] <= 1'b1;
					wr_ptr_q         <= wr_ptr_q + PW'(1);
					acc_q            <= acc_n;
					wcnt_q           <= wcnt_n;
					if (CMPW'(acc_n) >= CMPW'(kb_q)) begin
						res_status_q <= cpaf_pkg::ST_OK;
						res_pages_q  <= wcnt_n;
						res_start_q  <= best_start_q;
						free_q       <= free_q - wcnt_n;
						if (best_len_q == wcnt_n) begin
							runs_q <= runs_q - CW'(1);
						end
						state_q <= S_DONE;
					end
				end

				S_DONE: begin
					if (rsp_load) begin
						rsp_status_q <= res_status_q;
						rsp_pages_q  <= res_pages_q;
						rsp_start_q  <= res_start_q;
						rsp_free_q   <= free_q;
						rsp_runs_q   <= runs_q;
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
